>>> design/efx_pkg.sv
`default_nettype none

package efx_pkg;

    // Line codes
    localparam logic [7:0] FEND  = 8'hC0;
    localparam logic [7:0] FESC  = 8'hDB;
    localparam logic [7:0] TFEND = 8'hDC;
    localparam logic [7:0] TFESC = 8'hDD;

    localparam logic [7:0] NIBBLE_MASK = 8'h0F;
    localparam logic [7:0] LEN_OFFSET  = 8'd7;

    localparam logic [7:0] MAX_PAYLOAD = 8'd248;

    // Configuration registers
    localparam int          CFG_IDX_W        = 1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE     = 1'd1;
    localparam logic [7:0]  FRAME_TYPE_RESET = 8'hA0;
    localparam logic [7:0]  SOURCE_RESET     = 8'h42;

    // Byte slots of one transaction, in line order
    localparam int SLOT_W = 4;
    localparam int NUM_SLOTS = 10;
    localparam logic [SLOT_W-1:0] SLOT_LEAD   = 4'd0;
    localparam logic [SLOT_W-1:0] SLOT_FTYPE  = 4'd1;
    localparam logic [SLOT_W-1:0] SLOT_LEN    = 4'd2;
    localparam logic [SLOT_W-1:0] SLOT_DEST   = 4'd3;
    localparam logic [SLOT_W-1:0] SLOT_SRC    = 4'd4;
    localparam logic [SLOT_W-1:0] SLOT_MTYPE  = 4'd5;
    localparam logic [SLOT_W-1:0] SLOT_DATA   = 4'd6;
    localparam logic [SLOT_W-1:0] SLOT_XOR_HI = 4'd7;
    localparam logic [SLOT_W-1:0] SLOT_XOR_LO = 4'd8;
    localparam logic [SLOT_W-1:0] SLOT_CLOSE  = 4'd9;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FIFO_PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        logic [7:0] dest_id;
        logic [7:0] msg_type;
        logic [7:0] payload_len;
        logic [7:0] data_byte;
        logic       first_item;
        logic       last_item;
    } item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       frame_end;
        logic       run_last;
    } result_t;

    // Work descriptor for the byte sequencer
    typedef struct packed {
        logic            lead_fend;
        logic            lead_end;
        logic            hdr_en;
        logic [4:0][7:0] hdr;       // [0] frame type .. [4] msg type
        logic            data_en;
        logic [7:0]      data;
        logic            trl_en;
        logic [7:0]      xor_val;
        logic            close_en;
    } desc_t;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == FEND) || (b == FESC);
    endfunction

    function automatic logic [7:0] esc_code(input logic [7:0] b);
        return (b == FEND) ? TFEND : TFESC;
    endfunction

endpackage

`default_nettype wire

>>> design/efx_front.sv
`default_nettype none

module efx_front (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [efx_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [7:0]                        cfg_data,
    input  wire logic                              item_valid,
    output logic                                   item_ready,
    input  wire efx_pkg::item_t                    item,
    output logic                                   push,
    output efx_pkg::desc_t                         desc,
    input  wire logic                              full
);

    logic [7:0] frame_type_reg;
    logic [7:0] source_reg;
    logic       in_frame_reg, in_frame_next;
    logic [7:0] xor_reg, xor_next;
    logic       close_pend_reg, close_pend_next;

    logic       accept;
    logic       active;
    logic       data_en;
    logic [7:0] clen;
    logic [7:0] len_byte;
    logic [7:0] xor_upd;
    logic       defer;
    logic       any_bytes;

    assign item_ready = !full;
    assign accept     = item_valid && item_ready;

    always_comb
    begin
        active   = item.first_item || in_frame_reg;
        data_en  = active && (item.payload_len != 8'd0);
        clen     = (item.payload_len > efx_pkg::MAX_PAYLOAD) ? efx_pkg::MAX_PAYLOAD
                                                              : item.payload_len;
        len_byte = clen + efx_pkg::LEN_OFFSET;
        xor_upd  = (item.first_item ? 8'd0 : xor_reg) ^ (data_en ? item.data_byte : 8'd0);

        // A one-item frame with every header and data byte escaped fills all
        // fifteen result slots before the closing delimiter.
        defer = item.first_item && item.last_item && data_en
                && efx_pkg::needs_esc(frame_type_reg) && efx_pkg::needs_esc(len_byte)
                && efx_pkg::needs_esc(item.dest_id) && efx_pkg::needs_esc(source_reg)
                && efx_pkg::needs_esc(item.msg_type) && efx_pkg::needs_esc(item.data_byte);

        desc.lead_fend = item.first_item || close_pend_reg;
        desc.lead_end  = item.first_item ? close_pend_reg : 1'b1;
        desc.hdr_en    = item.first_item;
        desc.hdr[0]    = frame_type_reg;
        desc.hdr[1]    = len_byte;
        desc.hdr[2]    = item.dest_id;
        desc.hdr[3]    = source_reg;
        desc.hdr[4]    = item.msg_type;
        desc.data_en   = data_en;
        desc.data      = item.data_byte;
        desc.trl_en    = active && item.last_item;
        desc.xor_val   = data_en ? xor_upd : 8'd0;
        desc.close_en  = active && item.last_item && !defer;

        any_bytes = desc.lead_fend || desc.hdr_en || desc.data_en || desc.trl_en;
        push      = accept && any_bytes;

        in_frame_next   = in_frame_reg;
        xor_next        = xor_reg;
        close_pend_next = close_pend_reg;
        if (accept)
        begin
            close_pend_next = active && item.last_item && defer;
            if (active)
            begin
                in_frame_next = !item.last_item;
                xor_next      = item.last_item ? 8'd0 : xor_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_type_reg <= efx_pkg::FRAME_TYPE_RESET;
            source_reg     <= efx_pkg::SOURCE_RESET;
            in_frame_reg   <= 1'b0;
            xor_reg        <= 8'd0;
            close_pend_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    efx_pkg::REG_FRAME_TYPE: frame_type_reg <= cfg_data;
                    efx_pkg::REG_SOURCE:     source_reg     <= cfg_data;
                    default: ;
                endcase
            end
            in_frame_reg   <= in_frame_next;
            xor_reg        <= xor_next;
            close_pend_reg <= close_pend_next;
        end
    end

    // A deferred delimiter only follows a closed frame.
    a_pend_idle: assert property (@(posedge clk) disable iff (!rst_n)
        close_pend_reg |-> !in_frame_reg)
        else $error("close pending while frame open");

    // Idle frames carry no running checksum.
    a_xor_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_frame_reg |-> (xor_reg == 8'd0))
        else $error("checksum not cleared outside frame");

endmodule

`default_nettype wire

>>> design/efx_fifo.sv
`default_nettype none

module efx_fifo (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire efx_pkg::desc_t push_data,
    output logic                full,
    input  wire logic           pop,
    output efx_pkg::desc_t      head,
    output logic                empty
);

    localparam logic [efx_pkg::FIFO_PTR_W-1:0] LAST_PTR =
        efx_pkg::FIFO_PTR_W'(efx_pkg::FIFO_DEPTH - 1);
    localparam logic [efx_pkg::FIFO_CNT_W-1:0] DEPTH_CNT =
        efx_pkg::FIFO_CNT_W'(efx_pkg::FIFO_DEPTH);

    efx_pkg::desc_t mem [efx_pkg::FIFO_DEPTH];

    logic [efx_pkg::FIFO_PTR_W-1:0] wr_ptr_reg;
    logic [efx_pkg::FIFO_PTR_W-1:0] rd_ptr_reg;
    logic [efx_pkg::FIFO_CNT_W-1:0] count_reg;
    logic                           do_push;
    logic                           do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 1'b1;
                2'b01:   count_reg <= count_reg - 1'b1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("queue occupancy beyond depth");

endmodule

`default_nettype wire

>>> design/efx_back.sv
`default_nettype none

module efx_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire efx_pkg::desc_t head,
    input  wire logic           empty,
    output logic                pop,
    output logic                result_valid,
    input  wire logic           result_ready,
    output efx_pkg::result_t    result
);

    logic [efx_pkg::SLOT_W-1:0]    slot_reg;
    logic                          phase_reg;
    logic                          result_valid_reg;
    efx_pkg::result_t              result_reg;

    logic [efx_pkg::NUM_SLOTS-1:0] mask;
    logic [efx_pkg::NUM_SLOTS-1:0] avail;
    logic [efx_pkg::NUM_SLOTS-1:0] low_hot;
    logic [efx_pkg::SLOT_W-1:0]    cur;
    logic                          final_slot;
    logic [7:0]                    raw;
    logic                          esc_slot;
    logic                          need;
    logic                          step_done;
    logic                          load;
    logic                          fire;
    efx_pkg::result_t              emit;

    always_comb
    begin
        mask[efx_pkg::SLOT_LEAD]   = head.lead_fend;
        mask[efx_pkg::SLOT_FTYPE]  = head.hdr_en;
        mask[efx_pkg::SLOT_LEN]    = head.hdr_en;
        mask[efx_pkg::SLOT_DEST]   = head.hdr_en;
        mask[efx_pkg::SLOT_SRC]    = head.hdr_en;
        mask[efx_pkg::SLOT_MTYPE]  = head.hdr_en;
        mask[efx_pkg::SLOT_DATA]   = head.data_en;
        mask[efx_pkg::SLOT_XOR_HI] = head.trl_en;
        mask[efx_pkg::SLOT_XOR_LO] = head.trl_en;
        mask[efx_pkg::SLOT_CLOSE]  = head.close_en;

        for (int i = 0; i < efx_pkg::NUM_SLOTS; i++)
        begin
            avail[i] = mask[i] && (efx_pkg::SLOT_W'(i) >= slot_reg);
        end
        low_hot    = avail & (~avail + 1'b1);
        final_slot = ((avail & (avail - 1'b1)) == '0);
        cur = '0;
        for (int i = 0; i < efx_pkg::NUM_SLOTS; i++)
        begin
            if (low_hot[i])
            begin
                cur = cur | efx_pkg::SLOT_W'(i);
            end
        end

        case (cur)
            efx_pkg::SLOT_LEAD:   raw = efx_pkg::FEND;
            efx_pkg::SLOT_FTYPE:  raw = head.hdr[0];
            efx_pkg::SLOT_LEN:    raw = head.hdr[1];
            efx_pkg::SLOT_DEST:   raw = head.hdr[2];
            efx_pkg::SLOT_SRC:    raw = head.hdr[3];
            efx_pkg::SLOT_MTYPE:  raw = head.hdr[4];
            efx_pkg::SLOT_DATA:   raw = head.data;
            efx_pkg::SLOT_XOR_HI: raw = (head.xor_val >> 4) & efx_pkg::NIBBLE_MASK;
            efx_pkg::SLOT_XOR_LO: raw = head.xor_val & efx_pkg::NIBBLE_MASK;
            efx_pkg::SLOT_CLOSE:  raw = efx_pkg::FEND;
            default:              raw = efx_pkg::FEND;
        endcase

        esc_slot  = (cur >= efx_pkg::SLOT_FTYPE) && (cur <= efx_pkg::SLOT_DATA);
        need      = esc_slot && efx_pkg::needs_esc(raw);
        step_done = !need || phase_reg;

        if (need && !phase_reg)
        begin
            emit.out_byte = efx_pkg::FESC;
        end
        else if (need)
        begin
            emit.out_byte = efx_pkg::esc_code(raw);
        end
        else
        begin
            emit.out_byte = raw;
        end
        emit.frame_end = (cur == efx_pkg::SLOT_LEAD)  ? head.lead_end :
                         (cur == efx_pkg::SLOT_CLOSE);
        emit.run_last  = step_done && final_slot;

        load = !result_valid_reg || result_ready;
        fire = !empty && load;
        pop  = fire && step_done && final_slot;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg         <= '0;
            phase_reg        <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                result_valid_reg <= fire;
            end
            if (fire)
            begin
                if (!step_done)
                begin
                    phase_reg <= 1'b1;
                end
                else
                begin
                    phase_reg <= 1'b0;
                    slot_reg  <= final_slot ? '0 : cur + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= emit;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_end_is_fend: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.frame_end) |-> (result.out_byte == efx_pkg::FEND))
        else $error("frame_end on a byte other than the delimiter");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("sequencer retired a descriptor from an empty queue");

endmodule

`default_nettype wire

>>> design/escaped_frame_transmitter_top.sv
// Escaped frame transmitter: builds one delimited, byte-stuffed frame per message.
// Item channel (item_valid/item_ready/item): one transaction per payload byte. The
// transaction with first_item set opens the frame (delimiter, five header bytes),
// every in-frame transaction with a payload adds its data byte, and the one with last_item
// set appends the two checksum nibble bytes and the closing delimiter.
// Result channel (result_valid/result_ready/result): one line byte per transaction,
// frame_end marks a closing delimiter, run_last marks the last byte of an item.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 frame type,
// 1 source id) at the clock edge; write only while the block is idle.
// An item's first byte passes the descriptor queue and the output register.
// Throughput: one line byte per cycle while result_ready is high, set by the byte
// sequencer; a mid-frame data byte takes 1 or 2 line bytes, a single-item frame up
// to 15. Items that produce no bytes take no sequencer time.
// A two-entry descriptor queue parts the classifier from the sequencer, and the
// sequencer refills the output register whenever it is empty or its byte is taken.
// Stall: with result_ready low the output register holds, the sequencer waits,
// and item_ready drops once the queue is full.
// Reset (rst_n, async, active low): registers return to 0xA0 / 0x42, the frame
// state goes idle, queue and output register are emptied; no clearing pass.
`default_nettype none

module escaped_frame_transmitter_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [efx_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]                    cfg_data,
    input  wire logic                          item_valid,
    output logic                               item_ready,
    input  wire efx_pkg::item_t                item,
    output logic                               result_valid,
    input  wire logic                          result_ready,
    output efx_pkg::result_t                   result
);

    // Front to queue
    logic           push;
    efx_pkg::desc_t push_desc;
    logic           full;

    // Queue to back
    efx_pkg::desc_t head;
    logic           empty;
    logic           pop;

    // Classifier: owns the frame state and the configuration registers, turns
    // each accepted transaction into a descriptor of its byte slots.
    efx_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .item       (item),
        .push       (push),
        .desc       (push_desc),
        .full       (full)
    );

    efx_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_desc),
        .full      (full),
        .pop       (pop),
        .head      (head),
        .empty     (empty)
    );

    // Sequencer: walks enabled slots, escaping bytes, one a cycle unless stalled.
    efx_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .empty        (empty),
        .pop          (pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

`default_nettype wire

>>> tb/sv/tb_escaped_frame_transmitter_top.sv
`timescale 1ns / 1ps

module tb_escaped_frame_transmitter_top;

    localparam int RESET_CYCLES   = 8;
    localparam int MAX_LINE_BYTES = 15;   // bytes one item may put on the line
    localparam int SETTLE_CYCLES  = 8;    // covers items that emit nothing
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int PHASE_ITEMS    = 75;   // four random phases

    // ------------------------------------------------------------------
    // Clock, reset and DUT ports; every input starts at a known value
    // ------------------------------------------------------------------
    logic                          clk          = 1'b0;
    logic                          rst_n        = 1'b0;
    logic                          cfg_we       = 1'b0;
    logic [efx_pkg::CFG_IDX_W-1:0] cfg_index    = efx_pkg::REG_FRAME_TYPE;
    logic [7:0]                    cfg_data     = 8'h00;
    logic                          item_valid   = 1'b0;
    logic                          item_ready;
    efx_pkg::item_t                item         = '0;
    logic                          result_valid;
    logic                          result_ready = 1'b0;
    efx_pkg::result_t              result;

    always #5 clk = ~clk;

    escaped_frame_transmitter_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // ------------------------------------------------------------------
    // Encoder shadow state: registers, frame state and the expected line
    // ------------------------------------------------------------------
    logic [7:0] ftype_reg = efx_pkg::FRAME_TYPE_RESET;
    logic [7:0] src_reg   = efx_pkg::SOURCE_RESET;
    logic [7:0] run_xor   = 8'h00;
    logic       in_frame  = 1'b0;
    logic       close_due = 1'b0;   // closing delimiter pushed past the byte cap

    efx_pkg::result_t line_q[$];    // line bytes still to arrive, oldest first
    efx_pkg::result_t burst[$];     // bytes of the transaction being encoded

    int err_count   = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;         // no gaps on either side while set
    int stall_left  = 0;

    // Mostly short idle stretches, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 25);
    endfunction

    // Random byte, biased toward the two codes that need stuffing
    function automatic logic [7:0] pick_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return efx_pkg::FEND;
        else if (r == 1)
            return efx_pkg::FESC;
        else
            return 8'($urandom_range(0, 255));
    endfunction

    // Payload length: mostly legal, some zero, some above the clamp
    function automatic logic [7:0] pick_len();
        int r;
        r = $urandom_range(0, 19);
        if (r == 0)
            return 8'd0;
        else if (r == 1)
            return 8'($urandom_range(249, 255));
        else
            return 8'($urandom_range(1, 248));
    endfunction

    function automatic efx_pkg::item_t make_item(input logic [7:0] dest,
                                                 input logic [7:0] mtype,
                                                 input logic [7:0] plen,
                                                 input logic [7:0] data,
                                                 input logic first, input logic last);
        efx_pkg::item_t it;
        it.dest_id     = dest;
        it.msg_type    = mtype;
        it.payload_len = plen;
        it.data_byte   = data;
        it.first_item  = first;
        it.last_item   = last;
        return it;
    endfunction

    // Anything past the cap is dropped; only the closing delimiter can hit it
    function automatic void put_line(input logic [7:0] b, input logic fe);
        efx_pkg::result_t r;
        if (burst.size() < MAX_LINE_BYTES)
        begin
            r.out_byte  = b;
            r.frame_end = fe;
            r.run_last  = 1'b0;
            burst = {burst, r};
        end
    endfunction

    function automatic void put_stuffed(input logic [7:0] b);
        if (b == efx_pkg::FEND)
        begin
            put_line(efx_pkg::FESC, 1'b0);
            put_line(efx_pkg::TFEND, 1'b0);
        end
        else if (b == efx_pkg::FESC)
        begin
            put_line(efx_pkg::FESC, 1'b0);
            put_line(efx_pkg::TFESC, 1'b0);
        end
        else
        begin
            put_line(b, 1'b0);
        end
    endfunction

    // Line bytes caused by one accepted transaction, appended to line_q
    function automatic void encode_item(input efx_pkg::item_t it);
        logic [7:0] clen;
        logic [7:0] chk;
        logic       due;
        due       = close_due;
        close_due = 1'b0;
        burst.delete();
        if (it.first_item)
        begin
            // a deferred close and the opening delimiter share one byte
            clen = (it.payload_len > efx_pkg::MAX_PAYLOAD) ? efx_pkg::MAX_PAYLOAD
                                                          : it.payload_len;
            put_line(efx_pkg::FEND, due);
            in_frame = 1'b1;
            run_xor  = 8'h00;
            put_stuffed(ftype_reg);
            put_stuffed(clen + efx_pkg::LEN_OFFSET);
            put_stuffed(it.dest_id);
            put_stuffed(src_reg);
            put_stuffed(it.msg_type);
        end
        else if (due)
        begin
            put_line(efx_pkg::FEND, 1'b1);
        end
        if (in_frame)
        begin
            if (it.payload_len != 8'd0)
            begin
                put_stuffed(it.data_byte);
                run_xor = run_xor ^ it.data_byte;
            end
            if (it.last_item)
            begin
                chk = (it.payload_len != 8'd0) ? run_xor : 8'h00;
                put_line({4'h0, chk[7:4]}, 1'b0);
                put_line(chk & efx_pkg::NIBBLE_MASK, 1'b0);
                if (burst.size() < MAX_LINE_BYTES)
                    put_line(efx_pkg::FEND, 1'b1);
                else
                    close_due = 1'b1;
                in_frame = 1'b0;
                run_xor  = 8'h00;
            end
        end
        if (burst.size() > 0)
            burst[burst.size() - 1].run_last = 1'b1;
        foreach (burst[i])
            line_q = {line_q, burst[i]};
    endfunction

    // ------------------------------------------------------------------
    // Result side: random backpressure, checks sampled at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (calm)
        begin
            result_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            result_ready <= 1'b0;
            stall_left   <= stall_left - 1;
        end
        else
        begin
            result_ready <= 1'b1;
            stall_left   <= pick_idle();
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH at %0t: %s got %0h expected %0h", $realtime, what, got, want);
        err_count++;
    endtask

    // valid && ready at the falling edge means the transaction completes at the next
    // rising edge; the payload is stable here
    always @(negedge clk)
    begin : check_line
        efx_pkg::result_t want;
        if (rst_n && result_valid && result_ready)
        begin
            if (line_q.size() == 0)
            begin
                report_mismatch("unexpected line byte", result.out_byte, 0);
            end
            else
            begin
                want = line_q[0];
                line_q.delete(0);
                if (result.out_byte !== want.out_byte)
                    report_mismatch("out_byte", result.out_byte, want.out_byte);
                if (result.frame_end !== want.frame_end)
                    report_mismatch("frame_end", result.frame_end, want.frame_end);
                if (result.run_last !== want.run_last)
                    report_mismatch("run_last", result.run_last, want.run_last);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_escaped_frame_transmitter_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Item side: all tasks start and end right after a rising edge
    // ------------------------------------------------------------------
    task automatic send_item(input efx_pkg::item_t it);
        int gap;
        item       <= it;
        item_valid <= 1'b1;
        @(negedge clk);
        while (!item_ready)
            @(negedge clk);
        @(posedge clk);          // transaction accepted here
        encode_item(it);
        gap = calm ? 0 : pick_idle();
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Let every expected byte out, plus slack for transactions that emit none
    task automatic wait_drain();
        item_valid <= 1'b0;
        while (line_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Only called with the block drained
    task automatic set_config(input logic [7:0] ftype, input logic [7:0] src);
        cfg_we    <= 1'b1;
        cfg_index <= efx_pkg::REG_FRAME_TYPE;
        cfg_data  <= ftype;
        @(posedge clk);
        cfg_index <= efx_pkg::REG_SOURCE;
        cfg_data  <= src;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        ftype_reg = ftype;
        src_reg   = src;
    endtask

    // ------------------------------------------------------------------
    // Directed tests
    // ------------------------------------------------------------------

    // Plain three-byte message with the reset register values
    task automatic test_default_frame();
        send_item(make_item(8'h00, 8'hFF, 8'd3, 8'h00, 1'b1, 1'b0));
        send_item(make_item(8'h00, 8'h00, 8'd3, 8'hFF, 1'b0, 1'b0));
        send_item(make_item(8'h00, 8'h00, 8'd3, 8'h5A, 1'b0, 1'b1));
        wait_drain();
    endtask

    // Delimiter and escape codes in header and payload, back to back
    task automatic test_escaped_bytes();
        calm <= 1'b1;
        send_item(make_item(efx_pkg::FEND, efx_pkg::FESC, 8'd2, efx_pkg::FEND, 1'b1, 1'b0));
        send_item(make_item(efx_pkg::FESC, efx_pkg::FEND, 8'd2, efx_pkg::FESC, 1'b0, 1'b1));
        wait_drain();
        calm <= 1'b0;
    endtask

    // Zero length: data skipped, trailer forced to 0,0 even after real payload
    task automatic test_zero_length();
        send_item(make_item(8'h12, 8'h34, 8'd0, 8'hAB, 1'b1, 1'b1));
        send_item(make_item(8'h56, 8'h78, 8'd0, 8'hCD, 1'b1, 1'b0));
        send_item(make_item(8'h00, 8'h00, 8'd0, 8'hEF, 1'b0, 1'b1));
        send_item(make_item(8'h9A, 8'hBC, 8'd4, 8'h33, 1'b1, 1'b0));
        send_item(make_item(8'h00, 8'h00, 8'd0, 8'h44, 1'b0, 1'b1));
        wait_drain();
    endtask

    // Length byte hits C0 and DB, the top legal value, and the clamp
    task automatic test_length_clamp();
        send_item(make_item(8'h01, 8'h02, 8'd185, 8'h11, 1'b1, 1'b1));
        send_item(make_item(8'h03, 8'h04, 8'd212, 8'h22, 1'b1, 1'b1));
        send_item(make_item(8'h05, 8'h06, 8'd248, 8'h33, 1'b1, 1'b1));
        send_item(make_item(8'h07, 8'h08, 8'd255, 8'h44, 1'b1, 1'b1));
        wait_drain();
    endtask

    // Stray transaction while idle is dropped; a reopen abandons the frame
    task automatic test_stray_and_restart();
        send_item(make_item(8'hAA, 8'h55, 8'd5, 8'h55, 1'b0, 1'b1));
        send_item(make_item(8'h10, 8'h20, 8'd3, 8'h10, 1'b1, 1'b0));
        send_item(make_item(8'h30, 8'h40, 8'd2, 8'h20, 1'b1, 1'b0));
        send_item(make_item(8'h00, 8'h00, 8'd2, 8'h21, 1'b0, 1'b1));
        wait_drain();
    endtask

    // Single-item frame needing 16 bytes: closing delimiter rides on the next
    // transaction, alone when idle, merged with the opener when a frame starts
    task automatic test_deferred_close();
        set_config(efx_pkg::FEND, efx_pkg::FESC);
        send_item(make_item(efx_pkg::FEND, efx_pkg::FESC, 8'd212, efx_pkg::FEND, 1'b1, 1'b1));
        send_item(make_item(8'h00, 8'h00, 8'd5, 8'h11, 1'b0, 1'b0));
        send_item(make_item(efx_pkg::FEND, efx_pkg::FESC, 8'd212, efx_pkg::FESC, 1'b1, 1'b1));
        send_item(make_item(8'h01, 8'h02, 8'd2, efx_pkg::FESC, 1'b1, 1'b0));
        send_item(make_item(8'h00, 8'h00, 8'd2, 8'h7E, 1'b0, 1'b1));
        wait_drain();
    endtask

    // ------------------------------------------------------------------
    // Random traffic: mostly well-formed frames, some noise and broken ones
    // ------------------------------------------------------------------
    task automatic run_random_phase(input int target);
        int             sent;
        int             kind;
        int             nlen;
        logic [7:0]     plen;
        efx_pkg::item_t it;
        sent = 0;
        while (sent < target)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 6)
            begin
                // stray item: dropped when idle, a payload byte mid-frame
                it = make_item(pick_byte(), pick_byte(), pick_len(), pick_byte(),
                               1'b0, 1'($urandom_range(0, 1)));
                if (in_frame)
                    sent++;
                send_item(it);
            end
            else if (kind < 12)
            begin
                // opened and then abandoned by the next frame
                send_item(make_item(pick_byte(), pick_byte(), pick_len(), pick_byte(),
                                    1'b1, 1'b0));
                sent++;
            end
            else if (kind < 24)
            begin
                // one-item frame, escape heavy, can overflow the byte cap
                send_item(make_item(pick_byte(), pick_byte(), pick_len(), pick_byte(),
                                    1'b1, 1'b1));
                sent++;
            end
            else
            begin
                nlen = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                   : $urandom_range(2, 6);
                plen = ($urandom_range(0, 6) == 0) ? 8'($urandom_range(0, 255))
                                                   : 8'(nlen);
                for (int k = 0; k < nlen; k++)
                begin
                    it = make_item(pick_byte(), pick_byte(), plen, pick_byte(),
                                   1'(k == 0), 1'(k == nlen - 1));
                    if ($urandom_range(0, 15) == 0)
                        it.payload_len = 8'd0;
                    send_item(it);
                    sent++;
                end
            end
        end
        wait_drain();
    endtask

    task automatic test_random_traffic();
        set_config(8'h00, 8'hFF);
        run_random_phase(PHASE_ITEMS);
        set_config(8'hFF, 8'h00);
        calm <= 1'b1;               // a stretch with no gaps at all
        run_random_phase(PHASE_ITEMS);
        calm <= 1'b0;
        set_config(pick_byte(), pick_byte());
        run_random_phase(PHASE_ITEMS);
        set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
        run_random_phase(PHASE_ITEMS);
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_default_frame();
        test_escaped_bytes();
        test_zero_length();
        test_length_clamp();
        test_stray_and_restart();
        test_deferred_close();
        test_random_traffic();

        if (err_count == 0)
            $display("tb_escaped_frame_transmitter_top: done, clean");
        else
            $display("tb_escaped_frame_transmitter_top: done, errors");
        $finish;
    end

endmodule

>>> sim.f
design/efx_pkg.sv
design/efx_front.sv
design/efx_fifo.sv
design/efx_back.sv
design/escaped_frame_transmitter_top.sv
tb/sv/tb_escaped_frame_transmitter_top.sv
